// ===== sv/lkc_pkg.sv =====
// Shared types and constants of the letter cipher.
// Used by lkc_datapath, lkc_result_queue and lcg_keystream_letter_cipher.
package lkc_pkg;

    // Letter alphabet
    localparam logic [7:0] LETTER_BASE  = 8'd65;
    localparam logic [7:0] LETTER_COUNT = 8'd26;

    // Divide-by-26 for bytes: q = (c * 79) >> 11, exact for c < 256
    localparam logic [14:0] DIV_RECIP = 15'd79;
    localparam int          DIV_SHIFT = 11;

    // Register reset values
    localparam logic [15:0] MULT_RESET = 16'd52845;
    localparam logic [15:0] INCR_RESET = 16'd22719;

    // Cipher modes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Register indexes
    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_SEED = 2'd1,
        REG_MULT = 2'd2,
        REG_INCR = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] seed;
        logic [15:0] mult;
        logic [15:0] incr;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    // Up to two result beats produced by one item
    typedef struct packed {
        logic [1:0] count;
        beat_t      first;
        beat_t      second;
    } result_t;

endpackage

// ===== sv/lcg_keystream_letter_cipher.sv =====
// Letter cipher top level: configuration registers, input register and glue.
// Depends on lkc_pkg, lkc_datapath and lkc_result_queue.
//
// Usage:
//   Input beats (data_char, msg_start, msg_end) move on in_valid/in_stall,
//   result beats (out_char, out_last) on out_valid/out_stall. A beat moves
//   at a rising edge with valid high and stall low.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data while idle.
//   An accepted beat is held in the input register, then moves into the
//   two-slot result queue, whose head slot drives the output beat.
//   Throughput: decrypt takes one letter per cycle while the receiver does
//   not stall. Encrypt gives two letters per byte through the one-beat
//   output, so there the output limits how fast bytes are taken.
//   The input register waits until the queue has room for all results of
//   its beat; when the receiver stalls the queue fills and in_stall rises.
//   Reset clears the key, pairing state, queue and registers to their
//   defaults (multiplier 52845, increment 22719, encrypt mode).
module lcg_keystream_letter_cipher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_char,
    input  logic        msg_start,
    input  logic        msg_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        out_last
);

    lkc_pkg::cfg_t    cfg_reg;
    lkc_pkg::item_t   item_reg;
    logic             item_valid_reg;
    logic             item_valid_next;
    lkc_pkg::result_t res;
    lkc_pkg::beat_t   head;
    logic [1:0]       q_count;
    logic [2:0]       room;
    logic             pop;
    logic             fire;
    logic             accept;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= lkc_pkg::MODE_ENCRYPT;
            cfg_reg.seed <= '0;
            cfg_reg.mult <= lkc_pkg::MULT_RESET;
            cfg_reg.incr <= lkc_pkg::INCR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (lkc_pkg::reg_index_t'(cfg_index))
                lkc_pkg::REG_MODE: cfg_reg.mode <= cfg_data[0];
                lkc_pkg::REG_SEED: cfg_reg.seed <= cfg_data;
                lkc_pkg::REG_MULT: cfg_reg.mult <= cfg_data;
                lkc_pkg::REG_INCR: cfg_reg.incr <= cfg_data;
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake: process when the queue can take all results of the beat
    assign pop      = out_valid && !out_stall;
    assign room     = 3'd2 - {1'b0, q_count} + {2'd0, pop};
    assign fire     = item_valid_reg && ({1'b0, res.count} <= room);
    assign in_stall = item_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    // Input register
    always_comb
    begin
        if (accept)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data  <= data_char;
            item_reg.start <= msg_start;
            item_reg.last  <= msg_end;
        end
    end

    lkc_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (item_reg),
        .fire  (fire),
        .res   (res)
    );

    lkc_result_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (fire),
        .push       (res),
        .pop        (pop),
        .count      (q_count),
        .head_valid (out_valid),
        .head       (head)
    );

    assign out_char = head.data;
    assign out_last = head.last;

endmodule

// ===== sv/lkc_datapath.sv =====
// Cipher datapath: running key, letter pairing and key update.
// Depends on lkc_pkg.
module lkc_datapath
(
    input  logic            clk,
    input  logic            rst_n,
    input  lkc_pkg::cfg_t   cfg,
    input  lkc_pkg::item_t  item,
    input  logic            fire,
    output lkc_pkg::result_t res
);

    logic [15:0] key_reg;
    logic [15:0] key_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic        phase_reg;
    logic        phase_next;

    logic [15:0] key_cur;
    logic        phase_cur;
    logic [7:0]  enc_c;
    logic [7:0]  dec_c;
    logic [7:0]  cbyte;
    logic [14:0] quot_prod;
    logic [3:0]  quot;
    logic [7:0]  rem;
    logic [15:0] key_sum;
    logic [31:0] key_prod;
    logic [15:0] key_adv;

    // Message start reloads key and pairing
    assign key_cur   = item.start ? cfg.seed : key_reg;
    assign phase_cur = item.start ? 1'b0 : phase_reg;

    // Cipher byte for either mode
    assign enc_c = item.data ^ key_cur[15:8];
    assign dec_c = (held_reg - lkc_pkg::LETTER_BASE) * lkc_pkg::LETTER_COUNT
                 + (item.data - lkc_pkg::LETTER_BASE);
    assign cbyte = (cfg.mode == lkc_pkg::MODE_DECRYPT) ? dec_c : enc_c;

    // Split into base-26 digits by reciprocal multiply
    assign quot_prod = {7'd0, enc_c} * lkc_pkg::DIV_RECIP;
    assign quot      = 4'(quot_prod >> lkc_pkg::DIV_SHIFT);
    assign rem       = enc_c - {4'd0, quot} * lkc_pkg::LETTER_COUNT;

    // Key update, modulo 2^16
    assign key_sum  = {8'd0, cbyte} + key_cur;
    assign key_prod = key_sum * cfg.mult;
    assign key_adv  = key_prod[15:0] + cfg.incr;

    // Results and next state
    always_comb
    begin
        res        = '0;
        key_next   = key_cur;
        held_next  = held_reg;
        phase_next = phase_cur;
        if (cfg.mode == lkc_pkg::MODE_ENCRYPT)
        begin
            res.count       = 2'd2;
            res.first.data  = lkc_pkg::LETTER_BASE + {4'd0, quot};
            res.first.last  = 1'b0;
            res.second.data = lkc_pkg::LETTER_BASE + rem;
            res.second.last = item.last;
            key_next        = key_adv;
        end
        else if (!phase_cur)
        begin
            // first letter of a pair; dropped if it ends the message
            res.count = 2'd0;
            if (!item.last)
            begin
                held_next  = item.data;
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
            end
        end
        else
        begin
            res.count      = 2'd1;
            res.first.data = dec_c ^ key_cur[15:8];
            res.first.last = item.last;
            res.second     = res.first;
            key_next       = key_adv;
            phase_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            held_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else if (fire)
        begin
            key_reg   <= key_next;
            held_reg  <= held_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== sv/lkc_result_queue.sv =====
// Two-slot result queue; slot 0 drives the output beat.
// Depends on lkc_pkg.
module lkc_result_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  lkc_pkg::result_t push,
    input  logic             pop,
    output logic [1:0]       count,
    output logic             head_valid,
    output lkc_pkg::beat_t   head
);

    lkc_pkg::beat_t slot0_reg;
    lkc_pkg::beat_t slot0_next;
    lkc_pkg::beat_t slot1_reg;
    lkc_pkg::beat_t slot1_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    lkc_pkg::beat_t rem0;
    logic [1:0]     rem_n;
    logic [1:0]     push_n;

    assign push_n = push_en ? push.count : 2'd0;

    // Drop the popped beat, then append new beats
    always_comb
    begin
        if (pop)
        begin
            rem0  = slot1_reg;
            rem_n = count_reg - 2'd1;
        end
        else
        begin
            rem0  = slot0_reg;
            rem_n = count_reg;
        end
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (rem_n)
            2'd0:
            begin
                slot0_next = push.first;
                slot1_next = push.second;
            end
            2'd1:
            begin
                slot0_next = rem0;
                slot1_next = push.first;
            end
            default:
            begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        count_next = rem_n + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign count      = count_reg;
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot0_reg;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the letter cipher: directed script, then random messages in both modes.
// Needs lkc_pkg and lcg_keystream_letter_cipher. Results are checked against an
// in-bench key stream predictor.
`timescale 1ns / 100ps

module tb_top;

    typedef enum logic {
        ROW_CHAR,
        ROW_REG
    } row_kind_t;

    // One line of the directed script: a register write or a character beat
    typedef struct {
        row_kind_t           kind;
        lkc_pkg::reg_index_t reg_sel;
        logic [15:0]         value;
        logic [7:0]          ch;
        logic                st;
        logic                fin;
        logic                known;
        int unsigned         n_known;
        lkc_pkg::beat_t      k0;
        lkc_pkg::beat_t      k1;
    } script_row_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_wr_en = 1'b0;
    lkc_pkg::reg_index_t cfg_index = lkc_pkg::REG_MODE;
    logic [15:0]         cfg_data  = 16'h0000;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [7:0]          data_char = 8'h00;
    logic                msg_start = 1'b0;
    logic                msg_end   = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [7:0]          out_char;
    logic                out_last;

    // Predictor state: configuration copy, running key and letter pairing
    lkc_pkg::cfg_t model_cfg = {lkc_pkg::MODE_ENCRYPT, 16'h0000, lkc_pkg::MULT_RESET,
                                lkc_pkg::INCR_RESET};
    logic [15:0]   key_now   = 16'h0000;
    logic [7:0]    held_char = 8'h00;
    logic          pair_half = 1'b0;

    lkc_pkg::beat_t pending_beats[$];
    script_row_t    script[$];

    int unsigned tx_idle_pct  = 38;
    int unsigned rx_stall_pct = 57;
    int unsigned block_chars  = 0;
    int unsigned beats_seen   = 0;
    int unsigned mismatches   = 0;

    lcg_keystream_letter_cipher DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_char (data_char),
        .msg_start (msg_start),
        .msg_end   (msg_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Key update with cipher byte c, modulo 2^16
    function automatic void advance_key(input logic [7:0] c);
        logic [15:0] sum;
        sum     = {8'h00, c} + key_now;
        key_now = sum * model_cfg.mult + model_cfg.incr;
    endfunction

    // Cipher one character; returns the number of result beats it gives
    function automatic int unsigned predict_cipher(input logic [7:0] ch, input logic st,
                                                   input logic fin,
                                                   output lkc_pkg::beat_t b0,
                                                   output lkc_pkg::beat_t b1);
        logic [7:0] c;
        b0 = '0;
        b1 = '0;
        if (st)
        begin
            key_now   = model_cfg.seed;
            pair_half = 1'b0;
        end
        if (model_cfg.mode == lkc_pkg::MODE_ENCRYPT)
        begin
            c = ch ^ key_now[15:8];
            advance_key(c);
            b0.data = lkc_pkg::LETTER_BASE + c / lkc_pkg::LETTER_COUNT;
            b0.last = 1'b0;
            b1.data = lkc_pkg::LETTER_BASE + c % lkc_pkg::LETTER_COUNT;
            b1.last = fin;
            return 2;
        end
        // decrypt: first letter of a pair is held, a lone final letter is dropped
        if (!pair_half)
        begin
            if (!fin)
            begin
                held_char = ch;
                pair_half = 1'b1;
            end
            return 0;
        end
        c         = (held_char - lkc_pkg::LETTER_BASE) * lkc_pkg::LETTER_COUNT
                  + (ch - lkc_pkg::LETTER_BASE);
        pair_half = 1'b0;
        b0.data   = c ^ key_now[15:8];
        b0.last   = fin;
        advance_key(c);
        return 1;
    endfunction

    function automatic script_row_t char_row(input logic [7:0] ch, input logic st,
                                             input logic fin, input logic known = 1'b0,
                                             input int unsigned n = 0,
                                             input lkc_pkg::beat_t k0 = '0,
                                             input lkc_pkg::beat_t k1 = '0);
        script_row_t r;
        r.kind    = ROW_CHAR;
        r.reg_sel = lkc_pkg::REG_MODE;
        r.value   = 16'h0000;
        r.ch      = ch;
        r.st      = st;
        r.fin     = fin;
        r.known   = known;
        r.n_known = n;
        r.k0      = k0;
        r.k1      = k1;
        return r;
    endfunction

    function automatic script_row_t reg_row(input lkc_pkg::reg_index_t sel,
                                            input logic [15:0] val);
        script_row_t r;
        r         = char_row(8'h00, 1'b0, 1'b0);
        r.kind    = ROW_REG;
        r.reg_sel = sel;
        r.value   = val;
        return r;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drop valid and wait until every expected beat is in, then let the pipeline drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input lkc_pkg::reg_index_t sel, input logic [15:0] val);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (sel)
            lkc_pkg::REG_MODE: model_cfg.mode = val[0];
            lkc_pkg::REG_SEED: model_cfg.seed = val;
            lkc_pkg::REG_MULT: model_cfg.mult = val;
            lkc_pkg::REG_INCR: model_cfg.incr = val;
            default: model_cfg = model_cfg;
        endcase
    endtask

    // Offer one character beat; once taken, queue what it should produce
    task automatic offer_char(input logic [7:0] ch, input logic st, input logic fin,
                              input logic known = 1'b0, input int unsigned n_known = 0,
                              input lkc_pkg::beat_t k0 = '0,
                              input lkc_pkg::beat_t k1 = '0);
        int unsigned    gap;
        int unsigned    n;
        lkc_pkg::beat_t b0;
        lkc_pkg::beat_t b1;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_char <= ch;
        msg_start <= st;
        msg_end   <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = predict_cipher(ch, st, fin, b0, b1);
        if (known)
        begin
            n  = n_known;
            b0 = k0;
            b1 = k1;
        end
        if (n > 0)
            pending_beats.push_back(b0);
        if (n > 1)
            pending_beats.push_back(b1);
    endtask

    // One random message: mostly well formed, some odd-length, noisy or unframed
    task automatic send_message();
        int unsigned kind;
        int unsigned len;
        int unsigned i;
        logic [7:0]  ch;
        logic        st;
        logic        fin;
        kind = $urandom_range(9);
        len  = $urandom_range(1, 8);
        if (model_cfg.mode == lkc_pkg::MODE_DECRYPT)
            len = len * 2;
        if (kind == 7)
            len = len + 1;
        for (i = 0; i < len; i++)
        begin
            if (kind == 8 || model_cfg.mode == lkc_pkg::MODE_ENCRYPT)
                ch = 8'($urandom);
            else
                ch = lkc_pkg::LETTER_BASE + 8'($urandom_range(25));
            st  = (i == 0);
            fin = (i == len - 1);
            if (kind == 9)
            begin
                st  = ($urandom_range(7) == 0);
                fin = ($urandom_range(7) == 0);
            end
            offer_char(ch, st, fin);
            block_chars++;
        end
    endtask

    // Result side: check each beat, stall at random, and hold off long now and then
    initial
    begin : result_monitor
        lkc_pkg::beat_t want;
        int unsigned    hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                beats_seen++;
                if (pending_beats.size() == 0)
                begin
                    $error("out_char: no beat expected, actual %0h", out_char);
                    mismatches++;
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (out_char !== want.data)
                    begin
                        $error("out_char: expected %0h, actual %0h", want.data, out_char);
                        mismatches++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %0b, actual %0b", want.last, out_last);
                        mismatches++;
                    end
                end
                if (beats_seen == 150 || beats_seen == 420 || beats_seen == 700)
                    hold_left = 120;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    initial
    begin : stimulus
        logic [15:0] mode_word;
        int unsigned phase;
        int unsigned sub;

        // Encrypt from reset: seed 0, zero byte and all-ones byte
        script.push_back(char_row(8'h00, 1'b1, 1'b0, 1'b1, 2, {8'd65, 1'b0}, {8'd65, 1'b0}));
        script.push_back(char_row(8'hFF, 1'b0, 1'b1));
        script.push_back(char_row(8'hFF, 1'b1, 1'b1, 1'b1, 2, {8'd74, 1'b0}, {8'd86, 1'b1}));
        // All-ones seed cancels an all-ones byte
        script.push_back(reg_row(lkc_pkg::REG_SEED, 16'hFFFF));
        script.push_back(char_row(8'hFF, 1'b1, 1'b0, 1'b1, 2, {8'd65, 1'b0}, {8'd65, 1'b0}));
        script.push_back(char_row(8'h00, 1'b0, 1'b0));
        script.push_back(char_row(8'h5A, 1'b0, 1'b1));
        // Zero multiplier and increment: key collapses to zero after one byte
        script.push_back(reg_row(lkc_pkg::REG_MULT, 16'h0000));
        script.push_back(reg_row(lkc_pkg::REG_INCR, 16'h0000));
        script.push_back(char_row(8'h80, 1'b1, 1'b0, 1'b1, 2, {8'd69, 1'b0}, {8'd88, 1'b0}));
        script.push_back(char_row(8'h41, 1'b0, 1'b1, 1'b1, 2, {8'd67, 1'b0}, {8'd78, 1'b1}));
        script.push_back(reg_row(lkc_pkg::REG_MULT, 16'hFFFF));
        script.push_back(reg_row(lkc_pkg::REG_INCR, 16'hFFFF));
        script.push_back(char_row(8'h3C, 1'b1, 1'b0));
        script.push_back(char_row(8'hC3, 1'b0, 1'b1));
        // Decrypt with default key constants
        script.push_back(reg_row(lkc_pkg::REG_MODE, {15'd0, lkc_pkg::MODE_DECRYPT}));
        script.push_back(reg_row(lkc_pkg::REG_SEED, 16'h0000));
        script.push_back(reg_row(lkc_pkg::REG_MULT, lkc_pkg::MULT_RESET));
        script.push_back(reg_row(lkc_pkg::REG_INCR, lkc_pkg::INCR_RESET));
        script.push_back(char_row("A", 1'b1, 1'b0, 1'b1, 0));
        script.push_back(char_row("A", 1'b0, 1'b0, 1'b1, 1, {8'h00, 1'b0}));
        script.push_back(char_row("Z", 1'b0, 1'b0));
        script.push_back(char_row("Z", 1'b0, 1'b1));
        // lone final letter is dropped
        script.push_back(char_row("Q", 1'b1, 1'b1, 1'b1, 0));
        // letters outside A..Z wrap modulo 256
        script.push_back(char_row(8'h00, 1'b1, 1'b0, 1'b1, 0));
        script.push_back(char_row(8'hFF, 1'b0, 1'b1, 1'b1, 1, {8'd36, 1'b1}));
        // a new start drops the half-built pair
        script.push_back(char_row("X", 1'b1, 1'b0, 1'b1, 0));
        script.push_back(char_row("Y", 1'b1, 1'b0, 1'b1, 0));
        script.push_back(char_row("Z", 1'b0, 1'b1, 1'b1, 1, {8'd137, 1'b1}));
        // encrypt in the middle of a pair keeps the held letter, key runs on
        script.push_back(char_row("M", 1'b1, 1'b0));
        script.push_back(reg_row(lkc_pkg::REG_MODE, {15'd0, lkc_pkg::MODE_ENCRYPT}));
        script.push_back(char_row(8'h55, 1'b0, 1'b0));
        script.push_back(reg_row(lkc_pkg::REG_MODE, {15'd0, lkc_pkg::MODE_DECRYPT}));
        script.push_back(char_row("N", 1'b0, 1'b1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].reg_sel, script[i].value);
            else
                offer_char(script[i].ch, script[i].st, script[i].fin, script[i].known,
                           script[i].n_known, script[i].k0, script[i].k1);
        end

        // Random messages: three idling profiles, three settings each
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct  = 38;
                    rx_stall_pct = 57;
                end
                1:
                begin
                    tx_idle_pct  = 57;
                    rx_stall_pct = 38;
                end
                default:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            for (sub = 0; sub < 3; sub++)
            begin
                mode_word    = 16'($urandom);
                mode_word[0] = sub[0] ^ phase[0];
                write_reg(lkc_pkg::REG_MODE, mode_word);
                write_reg(lkc_pkg::REG_SEED, pick_word());
                write_reg(lkc_pkg::REG_MULT, pick_word());
                write_reg(lkc_pkg::REG_INCR, pick_word());
                block_chars = 0;
                while (block_chars < 80)
                    send_message();
            end
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
